FILE: hw/rtl/mdfd_pkg.sv
// Shared types, codes and constants of the magic-delimited frame deframer.
// No dependencies; every other file imports it.
package mdfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned FIELD_W  = 16;
    localparam int unsigned LEN_W    = 15;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned APB_W    = 32;

    // Register index, taken from paddr[2] (registers on 32-bit words)
    localparam logic REG_LEN_BE      = 1'b0;
    localparam logic REG_MAX_PAYLOAD = 1'b1;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 15'h7FFF;

    // Frame layout: positions within a frame
    localparam logic [FIELD_W-1:0] POS_TYPE    = 16'd4;
    localparam logic [FIELD_W-1:0] POS_LENGTH  = 16'd6;
    localparam logic [FIELD_W-1:0] POS_PAYLOAD = 16'd8;
    localparam logic [FIELD_W-1:0] POS_LEN_HI  = 16'd7;
    localparam logic [1:0]         TRL_LAST    = 2'd3;

    localparam logic [BYTE_W-1:0] HEAD_MAGIC [4] = '{8'h00, 8'h65, 8'h6E, 8'h64};
    localparam logic [BYTE_W-1:0] TAIL_MAGIC [4] = '{8'h64, 8'h6E, 8'h65, 8'h00};

    typedef enum logic [2:0] {
        ROLE_HEADER  = 3'd0,
        ROLE_TYPE    = 3'd1,
        ROLE_LENGTH  = 3'd2,
        ROLE_PAYLOAD = 3'd3,
        ROLE_TRAILER = 3'd4,
        ROLE_DISCARD = 3'd5
    } t_role;

    typedef enum logic [2:0] {
        ST_BUSY     = 3'd0,
        ST_GOOD     = 3'd1,
        ST_HDR_BAD  = 3'd2,
        ST_TRL_BAD  = 3'd3,
        ST_LEN_BAD  = 3'd4
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              restart;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        t_role              byte_role;
        logic               frame_last;
        t_status            frame_status;
        logic [FIELD_W-1:0] frame_type;
        logic [LEN_W-1:0]   payload_length;
    } t_out_item;

    typedef struct packed {
        logic             len_be;
        logic [LEN_W-1:0] max_payload;
    } t_cfg;

endpackage

FILE: hw/rtl/mdfd_if.sv
// Valid/ready stream interfaces for the deframer's byte input and result output.
// Depends on mdfd_pkg.
interface mdfd_in_if import mdfd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mdfd_out_if import mdfd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/magic_delimited_frame_deframer_unit.sv
// Top level of the magic-delimited frame deframer: config registers, parser, result queue.
// Depends on mdfd_pkg, mdfd_if, mdfd_regs, mdfd_parse and mdfd_outq.
//
// Usage
//  - i_in carries one received byte per transfer (data_byte) plus a restart
//    flag that drops any partial frame and clears the error latch first.
//  - o_out carries exactly one result per input byte, in order: the byte,
//    its role, frame_last, frame_status and the type/length seen so far.
//  - APB port: byte 0x0 = length_big_endian (bit 0), 0x4 = max_payload
//    (bits 14:0). pready is tied high; write only while the block is idle.
//  - Each result is registered in the result queue as its byte is taken.
//  - Throughput: one byte per cycle while the queue has room. The parser
//    updates its frame position, field accumulators and flags combinationally.
//  - Receiver stall: a two-entry result queue lets one more byte be taken
//    while a result waits; i_in.ready drops only once both entries are full.
//  - Reset (synchronous, active low) clears the frame state, the error
//    latch and the queue, and restores the registers to byte order little
//    endian and max_payload 32767. No clearing pass; ready at once.
module magic_delimited_frame_deframer_unit import mdfd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mdfd_in_if.sink           i_in,
    mdfd_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    t_cfg      cfg;
    t_out_item result;
    logic      q_ready;
    logic      in_xfer;

    // one input transfer per cycle whenever the queue has room
    assign i_in.ready = q_ready;
    assign in_xfer    = i_in.valid && q_ready;

    mdfd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // tags the byte and advances frame state on each transfer
    mdfd_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_xfer),
        .i_item   (i_in.payload),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // result register and skid entry towards the receiver
    mdfd_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_xfer),
        .i_item      (result),
        .o_ready     (q_ready),
        .o_valid     (o_out.valid),
        .o_item      (o_out.payload),
        .i_pop_ready (o_out.ready)
    );

endmodule

FILE: hw/rtl/mdfd_regs.sv
// APB-style configuration registers: length byte order and payload limit.
// Depends on mdfd_pkg.
module mdfd_regs import mdfd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.len_be      <= 1'b0;
            r_cfg.max_payload <= MAX_PAYLOAD_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_LEN_BE:      r_cfg.len_be      <= pwdata[0];
                REG_MAX_PAYLOAD: r_cfg.max_payload <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_LEN_BE:      prdata[0]         = r_cfg.len_be;
            REG_MAX_PAYLOAD: prdata[LEN_W-1:0] = r_cfg.max_payload;
            default: ;
        endcase
    end

endmodule

FILE: hw/rtl/mdfd_parse.sv
// Frame parser: state registers plus the single-pass next-state and tagging logic.
// Depends on mdfd_pkg.
module mdfd_parse import mdfd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic [FIELD_W-1:0] r_pos,  n_pos;
    logic [FIELD_W-1:0] r_type, n_type;
    logic [FIELD_W-1:0] r_len,  n_len;
    logic               r_tok,  n_tok;
    logic               r_err,  n_err;

    logic [FIELD_W-1:0] pos_e, type_e, len_e;
    logic               tok_e, err_e;
    logic [FIELD_W-1:0] trl_off;
    logic [FIELD_W-1:0] fld_acc, fld_new;
    logic [FIELD_W:0]   pay_end;
    logic [BYTE_W-1:0]  b;
    t_role              role;
    logic               last;
    t_status            status;

    assign b = i_item.data_byte;

    always_comb begin
        // restart wipes the frame before this byte
        pos_e  = i_item.restart ? '0   : r_pos;
        type_e = i_item.restart ? '0   : r_type;
        len_e  = i_item.restart ? '0   : r_len;
        tok_e  = i_item.restart ? 1'b1 : r_tok;
        err_e  = i_item.restart ? 1'b0 : r_err;

        n_pos  = pos_e;
        n_type = type_e;
        n_len  = len_e;
        n_tok  = tok_e;
        n_err  = err_e;
        role   = ROLE_DISCARD;
        last   = 1'b0;
        status = ST_BUSY;

        pay_end = {1'b0, POS_PAYLOAD} + {1'b0, len_e};
        trl_off = pos_e - POS_PAYLOAD - len_e;

        // shared byte placer for the type and length fields
        fld_acc = (pos_e < POS_LENGTH) ? type_e : len_e;
        if (i_cfg.len_be ^ pos_e[0]) begin
            fld_new = {b, fld_acc[BYTE_W-1:0]};
        end else begin
            fld_new = {fld_acc[FIELD_W-1:BYTE_W], b};
        end

        if (!err_e) begin
            if (pos_e < POS_TYPE) begin
                role = ROLE_HEADER;
                if (pos_e == '0) begin
                    n_type = '0;
                    n_len  = '0;
                    n_tok  = 1'b1;
                end
                if (b != HEAD_MAGIC[pos_e[1:0]]) begin
                    last   = 1'b1;
                    status = ST_HDR_BAD;
                    n_err  = 1'b1;
                    n_pos  = '0;
                end else begin
                    n_pos  = pos_e + 16'd1;
                end
            end else if (pos_e < POS_LENGTH) begin
                role   = ROLE_TYPE;
                n_type = fld_new;
                n_pos  = pos_e + 16'd1;
            end else if (pos_e < POS_PAYLOAD) begin
                role  = ROLE_LENGTH;
                n_len = fld_new;
                if (pos_e == POS_LEN_HI &&
                    (fld_new == '0 || fld_new > {1'b0, i_cfg.max_payload})) begin
                    last   = 1'b1;
                    status = ST_LEN_BAD;
                    n_pos  = '0;
                end else begin
                    n_pos  = pos_e + 16'd1;
                end
            end else if ({1'b0, pos_e} < pay_end) begin
                role  = ROLE_PAYLOAD;
                n_pos = pos_e + 16'd1;
            end else begin
                role = ROLE_TRAILER;
                if (b != TAIL_MAGIC[trl_off[1:0]]) begin
                    n_tok = 1'b0;
                end
                if (trl_off[1:0] == TRL_LAST) begin
                    last   = 1'b1;
                    status = n_tok ? ST_GOOD : ST_TRL_BAD;
                    n_pos  = '0;
                    n_tok  = 1'b1;
                end else begin
                    n_pos  = pos_e + 16'd1;
                end
            end
        end

        o_result.out_byte       = b;
        o_result.byte_role      = role;
        o_result.frame_last     = last;
        o_result.frame_status   = status;
        o_result.frame_type     = n_type;
        o_result.payload_length = n_len[LEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_type <= '0;
            r_len  <= '0;
            r_tok  <= 1'b1;
            r_err  <= 1'b0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_type <= n_type;
            r_len  <= n_len;
            r_tok  <= n_tok;
            r_err  <= n_err;
        end
    end

    a_err_parks_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> r_pos == '0)
        else $error("error latched with frame position not at zero");

    a_last_resyncs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_result.frame_last |=> r_pos == '0)
        else $error("frame end did not return to header byte 0");

    a_hdr_bad_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_result.frame_status == ST_HDR_BAD |=> r_err)
        else $error("header mismatch did not latch the error");

endmodule

FILE: hw/rtl/mdfd_outq.sv
// Two-entry result queue: output register plus skid entry.
// Depends on mdfd_pkg.
module mdfd_outq import mdfd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_item,
    output logic      o_ready,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_pop_ready
);

    t_out_item  r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign pop     = o_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_cnt != 2'd2)
        else $error("push into a full result queue");

endmodule

FILE: verif/tb_top.sv
// Testbench for magic_delimited_frame_deframer_unit: drives byte transfers, predicts each tagged
// result in step with the input, and checks every result transfer field by field.
// Depends on mdfd_pkg, mdfd_if and the deframer RTL.
`timescale 1ns / 100ps

module tb_top;
    import mdfd_pkg::*;

    localparam int unsigned LONG_HOLD = 300;          // receiver hold-off, in cycles
    localparam time         RUN_LIMIT = 6_000_000;    // ns, far beyond the slowest correct run

    localparam logic [ADDR_W-1:0] ADDR_LEN_BE      = {REG_LEN_BE, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_MAX_PAYLOAD = {REG_MAX_PAYLOAD, 2'b00};

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    mdfd_in_if  byte_if ();
    mdfd_out_if res_if ();

    magic_delimited_frame_deframer_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Deframer state as the testbench sees it, advanced once per accepted
    // byte transfer. Register copies change only while the block is idle.
    // ------------------------------------------------------------------
    logic                cfg_be;
    logic [LEN_W-1:0]    cfg_max;
    logic [FIELD_W-1:0]  fr_pos;
    logic [FIELD_W-1:0]  fr_len;
    logic [FIELD_W-1:0]  fr_type;
    logic                fr_trl_ok;
    logic                fr_err;

    t_out_item results_due [$];     // predicted results, oldest first
    t_in_item  frame_bytes [$];     // byte sequence being assembled for sending

    int unsigned fail_count   = 0;
    int unsigned bytes_sent   = 0;
    int unsigned settings_run = 0;
    int unsigned n_good = 0, n_hdr_bad = 0, n_trl_bad = 0, n_len_bad = 0;

    bit idle_on     = 1'b1;         // random idling allowed on both sides
    bit gaps_on     = 1'b1;         // sender gaps for the current sequence
    bit need_restart = 1'b0;        // next sequence must open with a restart
    bit hold_req    = 1'b0;
    bit hold_active = 1'b0;
    int unsigned hold_cycles;

    // Place a field byte as its high or low half, following the byte order
    function automatic logic [FIELD_W-1:0] put_byte(input logic [FIELD_W-1:0] acc,
                                                    input logic [BYTE_W-1:0] b,
                                                    input bit second);
        bit hi;
        hi = cfg_be ? !second : second;
        return hi ? {b, acc[7:0]} : {acc[15:8], b};
    endfunction

    // Tag one byte and advance the frame state
    function automatic t_out_item deframe_byte(input logic [BYTE_W-1:0] b, input logic rs);
        t_out_item   r;
        logic [16:0] k;
        r.out_byte     = b;
        r.byte_role    = ROLE_DISCARD;
        r.frame_last   = 1'b0;
        r.frame_status = ST_BUSY;
        if (rs) begin
            fr_pos = '0; fr_len = '0; fr_type = '0; fr_trl_ok = 1'b1; fr_err = 1'b0;
        end
        if (!fr_err) begin
            if (fr_pos < POS_TYPE) begin
                r.byte_role = ROLE_HEADER;
                if (fr_pos == '0) begin
                    fr_len = '0; fr_type = '0; fr_trl_ok = 1'b1;
                end
                if (b != HEAD_MAGIC[fr_pos[1:0]]) begin
                    // bad header byte: flag it, then discard until restart
                    r.frame_last   = 1'b1;
                    r.frame_status = ST_HDR_BAD;
                    fr_err = 1'b1;
                    fr_pos = '0;
                end else begin
                    fr_pos = fr_pos + 1'b1;
                end
            end else if (fr_pos < POS_LENGTH) begin
                r.byte_role = ROLE_TYPE;
                fr_type = put_byte(fr_type, b, fr_pos == POS_LENGTH - 1'b1);
                fr_pos  = fr_pos + 1'b1;
            end else if (fr_pos < POS_PAYLOAD) begin
                r.byte_role = ROLE_LENGTH;
                fr_len = put_byte(fr_len, b, fr_pos == POS_LEN_HI);
                if (fr_pos == POS_LEN_HI && (fr_len == '0 || fr_len > {1'b0, cfg_max})) begin
                    // zero or oversize length aborts; the next byte opens a frame
                    r.frame_last   = 1'b1;
                    r.frame_status = ST_LEN_BAD;
                    fr_pos = '0;
                end else begin
                    fr_pos = fr_pos + 1'b1;
                end
            end else if ({1'b0, fr_pos} < {1'b0, POS_PAYLOAD} + {1'b0, fr_len}) begin
                r.byte_role = ROLE_PAYLOAD;
                fr_pos = fr_pos + 1'b1;
            end else begin
                // trailer: mismatches gathered, verdict on the last byte
                k = {1'b0, fr_pos} - {1'b0, POS_PAYLOAD} - {1'b0, fr_len};
                r.byte_role = ROLE_TRAILER;
                if (k > 17'd3 || b != TAIL_MAGIC[k[1:0]])
                    fr_trl_ok = 1'b0;
                if (k >= 17'd3) begin
                    r.frame_last   = 1'b1;
                    r.frame_status = fr_trl_ok ? ST_GOOD : ST_TRL_BAD;
                    fr_pos    = '0;
                    fr_trl_ok = 1'b1;
                end else begin
                    fr_pos = fr_pos + 1'b1;
                end
            end
        end
        r.frame_type     = fr_type;
        r.payload_length = fr_len[LEN_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("Timed out with %0d results still due", results_due.size());
        $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted byte transfer queues its prediction; every
    // result transfer is compared with the oldest one.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        t_out_item got;
        if (i_rst_n) begin
            if (byte_if.valid && byte_if.ready)
                results_due.insert(results_due.size(),
                                   deframe_byte(byte_if.payload.data_byte,
                                                byte_if.payload.restart));
            if (res_if.valid && res_if.ready) begin
                got = res_if.payload;
                if (results_due.size() == 0) begin
                    report_mismatch("result transfer with nothing due", got.out_byte, 0);
                end else begin
                    want = results_due[0];
                    results_due.delete(0);
                    if (got.out_byte != want.out_byte)
                        report_mismatch("out_byte", got.out_byte, want.out_byte);
                    if (got.byte_role != want.byte_role)
                        report_mismatch("byte_role", got.byte_role, want.byte_role);
                    if (got.frame_last != want.frame_last)
                        report_mismatch("frame_last", got.frame_last, want.frame_last);
                    if (got.frame_status != want.frame_status)
                        report_mismatch("frame_status", got.frame_status, want.frame_status);
                    if (got.frame_type != want.frame_type)
                        report_mismatch("frame_type", got.frame_type, want.frame_type);
                    if (got.payload_length != want.payload_length)
                        report_mismatch("payload_length", got.payload_length,
                                        want.payload_length);
                    case (want.frame_status)
                        ST_GOOD:    n_good++;
                        ST_HDR_BAD: n_hdr_bad++;
                        ST_TRL_BAD: n_trl_bad++;
                        ST_LEN_BAD: n_len_bad++;
                        default: ;
                    endcase
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls and long high stretches; on request
    // one long hold-off so the result queue fills and the input stalls.
    // Exactly one assignment to ready per pass, then at least one edge.
    // ------------------------------------------------------------------
    initial begin : result_sink
        forever begin
            if (hold_req) begin
                res_if.ready <= 1'b0;
                hold_active = 1'b1;
                for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++)
                    @(posedge i_clk);
                hold_active = 1'b0;
                hold_req    = 1'b0;
            end else if (!idle_on) begin
                res_if.ready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [APB_W-1:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_check(input logic [ADDR_W-1:0] addr, input logic [APB_W-1:0] want);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want)
            report_mismatch($sformatf("register read at 0x%0h", addr), prdata, want);
        psel <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Byte transfers
    // ------------------------------------------------------------------
    task automatic send_byte(input t_in_item it);
        byte_if.valid   <= 1'b1;
        byte_if.payload <= it;
        @(posedge i_clk);
        while (!byte_if.ready) @(posedge i_clk);
        bytes_sent++;
        if (gaps_on && idle_on && $urandom_range(0, 7) == 0) begin
            byte_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic send_frame_bytes();
        t_in_item it;
        while (frame_bytes.size() != 0) begin
            it = frame_bytes[0];
            frame_bytes.delete(0);
            send_byte(it);
        end
    endtask

    // Stop offering bytes and let every due result arrive
    task automatic wait_idle();
        byte_if.valid <= 1'b0;
        do @(posedge i_clk); while (results_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input logic be, input logic [LEN_W-1:0] max_len);
        wait_idle();
        reg_write(ADDR_LEN_BE, {{(APB_W-1){1'b0}}, be});
        reg_write(ADDR_MAX_PAYLOAD, {{(APB_W-LEN_W){1'b0}}, max_len});
        reg_check(ADDR_LEN_BE, {{(APB_W-1){1'b0}}, be});
        reg_check(ADDR_MAX_PAYLOAD, {{(APB_W-LEN_W){1'b0}}, max_len});
        cfg_be  = be;
        cfg_max = max_len;
        settings_run++;
    endtask

    // ------------------------------------------------------------------
    // Sequence builders
    // ------------------------------------------------------------------
    function automatic void add_byte(input logic [BYTE_W-1:0] b);
        t_in_item it;
        it.data_byte = b;
        it.restart   = 1'b0;
        frame_bytes.insert(frame_bytes.size(), it);
    endfunction

    // 16-bit field in the current byte order
    function automatic void add_field(input logic [FIELD_W-1:0] v);
        if (cfg_be) begin
            add_byte(v[15:8]); add_byte(v[7:0]);
        end else begin
            add_byte(v[7:0]); add_byte(v[15:8]);
        end
    endfunction

    function automatic void add_frame(input logic [FIELD_W-1:0] typ,
                                      input logic [FIELD_W-1:0] plen);
        for (int i = 0; i < 4; i++) add_byte(HEAD_MAGIC[i]);
        add_field(typ);
        add_field(plen);
        repeat (plen) add_byte(8'($urandom_range(0, 255)));
        for (int i = 0; i < 4; i++) add_byte(TAIL_MAGIC[i]);
    endfunction

    function automatic logic [FIELD_W-1:0] pick_length();
        int unsigned n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
        if (n > cfg_max) n = $urandom_range(1, cfg_max);
        return FIELD_W'(n);
    endfunction

    // Mostly well-formed frames with random content; the rest broken or noise
    function automatic void build_random_sequence();
        int unsigned kind;
        int unsigned j;
        int unsigned cut;
        bit          rs;
        logic [FIELD_W-1:0] bad_len;
        kind = $urandom_range(0, 99);
        rs   = need_restart || ($urandom_range(0, 7) == 0);
        need_restart = 1'b0;
        if (kind < 58) begin
            add_frame(16'($urandom_range(0, 65535)), pick_length());
        end else if (kind < 68) begin
            // corrupt one or two trailer bytes
            add_frame(16'($urandom_range(0, 65535)), pick_length());
            repeat ($urandom_range(1, 2)) begin
                j = frame_bytes.size() - 1 - $urandom_range(0, 3);
                frame_bytes[j].data_byte ^= 8'($urandom_range(1, 255));
            end
        end else if (kind < 76) begin
            // header breaks at a random byte, then bytes discarded in error
            j = $urandom_range(0, 3);
            for (int i = 0; i < j; i++) add_byte(HEAD_MAGIC[i]);
            add_byte(HEAD_MAGIC[j] ^ 8'($urandom_range(1, 255)));
            repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
            need_restart = 1'b1;
        end else if (kind < 86) begin
            // zero length, or just past the limit up to all ones
            if ($urandom_range(0, 2) == 0)
                bad_len = '0;
            else if ($urandom_range(0, 1) == 0)
                bad_len = {1'b0, cfg_max} + 1'b1;
            else
                bad_len = 16'($urandom_range(cfg_max + 1, 65535));
            for (int i = 0; i < 4; i++) add_byte(HEAD_MAGIC[i]);
            add_field(16'($urandom_range(0, 65535)));
            add_field(bad_len);
        end else if (kind < 94) begin
            // frame cut short, dropped by a restart on the next sequence
            add_frame(16'($urandom_range(0, 65535)), pick_length());
            cut = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            need_restart = 1'b1;
        end else begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
            need_restart = 1'b1;
        end
        frame_bytes[0].restart = rs;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_register_defaults();
        reg_check(ADDR_LEN_BE, '0);
        reg_check(ADDR_MAX_PAYLOAD, {{(APB_W-LEN_W){1'b0}}, MAX_PAYLOAD_RST});
    endtask

    // Good frame with extreme bytes, header fault, discarded byte, restart
    // into a zero-length frame (little endian, default limit)
    task automatic test_directed_frames();
        add_frame(16'hFFFF, 16'd1);
        frame_bytes[8].data_byte = 8'h00;
        add_byte(8'hFF);                    // header fault on the first byte
        add_byte(8'h00);                    // discarded while in error
        for (int i = 0; i < 4; i++) add_byte(HEAD_MAGIC[i]);
        frame_bytes[15].restart = 1'b1;     // restart clears the error
        add_field(16'h1234);
        add_field(16'h0000);                // zero length
        send_frame_bytes();
        wait_idle();
    endtask

    // Big-endian fields and the smallest limit: good, oversize, bad trailer
    task automatic test_config_extremes();
        set_config(1'b1, 15'd1);
        add_frame(16'hABCD, 16'd1);
        for (int i = 0; i < 4; i++) add_byte(HEAD_MAGIC[i]);
        add_field(16'h00FF);
        add_field(16'd2);                   // one above the limit
        add_frame(16'h8001, 16'd1);
        frame_bytes[frame_bytes.size() - 2].data_byte = 8'h00;
        send_frame_bytes();
        wait_idle();
    endtask

    // Receiver holds off for a long stretch while bytes keep coming
    task automatic test_backpressure();
        set_config(1'b0, MAX_PAYLOAD_RST);
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        wait (hold_active);
        repeat (3) add_frame(16'($urandom_range(0, 65535)), 16'd4);
        send_frame_bytes();
        gaps_on = 1'b1;
        wait (!hold_req);
        wait_idle();
    endtask

    task automatic run_phase(input logic be, input logic [LEN_W-1:0] max_len,
                             input int unsigned n_bytes, input bit idling);
        int unsigned start;
        set_config(be, max_len);
        idle_on = idling;
        start   = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            gaps_on = ($urandom_range(0, 2) != 0);
            build_random_sequence();
            send_frame_bytes();
        end
    endtask

    task automatic test_random_traffic();
        run_phase(1'b0, MAX_PAYLOAD_RST, 300, 1'b1);
        run_phase(1'b1, MAX_PAYLOAD_RST, 300, 1'b1);
        run_phase(1'b1, 15'd1, 250, 1'b1);
        run_phase(1'b0, 15'd9, 300, 1'b1);
        run_phase(1'b1, 15'd300, 300, 1'b1);
        run_phase(1'b0, MAX_PAYLOAD_RST, 350, 1'b0);   // closing stretch, no idling
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        byte_if.valid   <= 1'b0;
        byte_if.payload <= '0;
        cfg_be    = 1'b0;
        cfg_max   = MAX_PAYLOAD_RST;
        fr_pos    = '0;
        fr_len    = '0;
        fr_type   = '0;
        fr_trl_ok = 1'b1;
        fr_err    = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_defaults();
        test_directed_frames();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d bytes under %0d register settings, with stalls on both sides",
                 bytes_sent, settings_run);
        $display("Frames ended: %0d good, %0d header, %0d trailer, %0d length faults",
                 n_good, n_hdr_bad, n_trl_bad, n_len_bad);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
